// ----- src/adnp_pkg.sv -----
// ----------------------------------------------------------------------------
// adnp_pkg
// Types and constants shared by the ASCII decimal number parser.
// ----------------------------------------------------------------------------
package adnp_pkg;

    localparam int PADDR_W = 3;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [5:0] FRAC_MAX = 6'd63;

    // word index of the configuration registers (paddr[2])
    localparam logic REG_PARSE_MODE = 1'b0;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_DECIMAL  = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [31:0] mantissa;
        logic        is_negative;
        logic [5:0]  fraction_digits;
        logic        overflowed;
    } parse_result_t;

    typedef struct packed {
        logic       sign_seen;
        logic       in_fraction;
        logic [5:0] fraction_count;
        logic       scan_stopped;
        logic       at_first_char;
        logic       saturated;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        sign_seen:      1'b0,
        in_fraction:    1'b0,
        fraction_count: 6'd0,
        scan_stopped:   1'b0,
        at_first_char:  1'b1,
        saturated:      1'b0
    };

endpackage

// ----- src/adnp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// adnp_cfg_regs
// APB-style register file holding the parse mode.
// ----------------------------------------------------------------------------
module adnp_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [adnp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        parse_mode
);
    import adnp_pkg::*;

    logic parse_mode_reg;
    logic parse_mode_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        parse_mode_next = parse_mode_reg;
        if (wr_en && paddr[2] == REG_PARSE_MODE)
        begin
            parse_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_mode_reg <= MODE_DECIMAL;
        end
        else
        begin
            parse_mode_reg <= parse_mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_PARSE_MODE: prdata = {31'd0, parse_mode_reg};
            default:        prdata = '0;
        endcase
    end

    assign parse_mode = parse_mode_reg;

endmodule

// ----- src/adnp_digit_step.sv -----
// ----------------------------------------------------------------------------
// adnp_digit_step
// One character of scan: classify, accumulate value*10+digit with saturation.
// ----------------------------------------------------------------------------
module adnp_digit_step #(
    parameter int MANTISSA_BITS = 32
)
(
    input  adnp_pkg::char_item_t      item,
    input  logic                      parse_mode,
    input  adnp_pkg::scan_state_t     state,
    input  logic [MANTISSA_BITS-1:0]  acc,
    output adnp_pkg::scan_state_t     state_next,
    output logic [MANTISSA_BITS-1:0]  acc_next
);
    import adnp_pkg::*;

    localparam int WIDE_BITS = MANTISSA_BITS + 4;

    logic                 is_digit;
    logic [3:0]           digit;
    logic [WIDE_BITS-1:0] acc_wide;
    logic [WIDE_BITS-1:0] acc_times_ten;
    logic                 acc_ovf;

    assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    assign digit    = item.char_code[3:0];

    // x*10 + d as two shifts and two adds
    assign acc_wide      = WIDE_BITS'(acc);
    assign acc_times_ten = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(digit);
    assign acc_ovf       = |acc_times_ten[WIDE_BITS-1:MANTISSA_BITS];

    always_comb
    begin
        state_next               = state;
        acc_next                 = acc;
        state_next.at_first_char = 1'b0;
        if (!state.scan_stopped)
        begin
            if (is_digit)
            begin
                if (state.in_fraction)
                begin
                    if (state.fraction_count == FRAC_MAX)
                    begin
                        state_next.saturated = 1'b1;
                    end
                    else
                    begin
                        state_next.fraction_count = state.fraction_count + 6'd1;
                    end
                end
                if (acc_ovf)
                begin
                    acc_next             = '1;
                    state_next.saturated = 1'b1;
                end
                else
                begin
                    acc_next = acc_times_ten[MANTISSA_BITS-1:0];
                end
            end
            else if (parse_mode == MODE_DECIMAL && item.char_code == CH_MINUS &&
                     state.at_first_char)
            begin
                state_next.sign_seen = 1'b1;
            end
            else if (parse_mode == MODE_DECIMAL && item.char_code == CH_POINT)
            begin
                state_next.in_fraction = 1'b1;
            end
            else
            begin
                state_next.scan_stopped = 1'b1;
            end
        end
    end

endmodule

// ----- src/ascii_decimal_number_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// Parses a stream of ASCII characters into a decimal mantissa, sign and
// fraction digit count, one result per buffer on its last character.
//
// The block takes one character per clock cycle while input ready is high. A
// character is held in an input register, scanned by a combinational
// shift-and-add step that closes the accumulator loop; a buffer's result is
// loaded from the input register's last character into the result register,
// which drives result valid. The result register lets the next buffer's
// characters keep flowing while a result waits; input ready drops only when
// a last character finds the result register still occupied.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser #(
    parameter int MANTISSA_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         char_valid,
    output logic                         char_ready,
    input  adnp_pkg::char_item_t         char_item,

    output logic                         result_valid,
    input  logic                         result_ready,
    output adnp_pkg::parse_result_t      result_item,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adnp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import adnp_pkg::*;

    logic                     parse_mode;

    logic                     item_valid_reg;
    logic                     item_valid_next;
    char_item_t               item_reg;

    scan_state_t              state_reg;
    scan_state_t              state_next;
    scan_state_t              state_step;
    logic [MANTISSA_BITS-1:0] acc_reg;
    logic [MANTISSA_BITS-1:0] acc_next;
    logic [MANTISSA_BITS-1:0] acc_step;

    logic                     result_valid_reg;
    logic                     result_valid_next;
    parse_result_t            result_reg;

    logic                     advance;
    logic                     emit;

    adnp_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .parse_mode (parse_mode)
    );

    adnp_digit_step #(
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_digit_step (
        .item       (item_reg),
        .parse_mode (parse_mode),
        .state      (state_reg),
        .acc        (acc_reg),
        .state_next (state_step),
        .acc_next   (acc_step)
    );

    assign advance    = item_valid_reg &&
                        (!item_reg.last_char || !result_valid_reg || result_ready);
    assign emit       = advance && item_reg.last_char;
    assign char_ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (char_ready)
        begin
            item_valid_next = char_valid;
        end

        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (emit)
        begin
            result_valid_next = 1'b1;
        end

        state_next = state_reg;
        acc_next   = acc_reg;
        if (advance)
        begin
            if (item_reg.last_char)
            begin
                state_next = SCAN_STATE_RESET;
                acc_next   = '0;
            end
            else
            begin
                state_next = state_step;
                acc_next   = acc_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= SCAN_STATE_RESET;
            acc_reg          <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            state_reg        <= state_next;
            acc_reg          <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            item_reg <= char_item;
        end
        if (emit)
        begin
            result_reg.mantissa        <= 32'(acc_step);
            result_reg.is_negative     <= state_step.sign_seen;
            result_reg.fraction_digits <= state_step.fraction_count;
            result_reg.overflowed      <= state_step.saturated;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule

// ----- src/adnp_checker.sv -----
// ----------------------------------------------------------------------------
// adnp_checker
// Port-level assertions for the ASCII decimal number parser.
// ----------------------------------------------------------------------------
module adnp_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         char_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input adnp_pkg::parse_result_t      result_item,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [adnp_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                  pwdata,
    input logic [31:0]                  prdata,
    input logic                         pready
);
    import adnp_pkg::*;

    // a stalled result transfer keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result changed while stalled");

    // input backpressure only comes from a blocked result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> result_valid && !result_ready)
        else $error("input stalled without a blocked result");

    // mode register reads back what was written
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_PARSE_MODE
        |=> paddr[2] != REG_PARSE_MODE || prdata[0] == $past(pwdata[0]))
        else $error("parse mode readback mismatch");

    a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:1] == 31'd0)
        else $error("unused register bits not zero");

endmodule

bind ascii_decimal_number_parser adnp_checker u_adnp_checker (.*);
